// ===== hdl/mva_pkg.sv =====
// Package for the MIDI voice allocator: message codes, command codes and the
// control and status structs that join the controller to the datapath.
// No dependencies.
package mva_pkg;

	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0] KIND_CONTROL  = 4'hb;
	localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
	localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
	localparam logic [4:0] MAX_RESULTS = 5'd16;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_FADE  = 2'd1;
	localparam logic [1:0] CMD_OFF   = 2'd2;

	localparam logic [1:0] REG_SECTION_COUNT = 2'd0;
	localparam logic [1:0] REG_SECTION_NOTES = 2'd1;
	localparam logic [1:0] REG_SAMPLE_LOADED = 2'd2;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ON   = 2'd1,
		KIND_OFF  = 2'd2,
		KIND_CC   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_FADE = 2'd0,
		MODE_FIND = 2'd1,
		MODE_REL  = 2'd2,
		MODE_ALL  = 2'd3
	} mode_t;

	typedef struct packed {
		logic  load;
		logic  step;
		mode_t mode;
		logic  start;
		logic  sec_clr;
		logic  sec_next;
		logic  flush;
	} ctrl_t;

	typedef struct packed {
		kind_t kind;
		logic  sec_done;
		logic  sec_hit;
		logic  scan_last;
		logic  emit_ok;
		logic  flush_ok;
	} stat_t;

endpackage

// ===== hdl/mva_ctrl.sv =====
// Controller of the MIDI voice allocator: one-hot sequencer over sections and
// voice scans. Depends on mva_pkg.
module mva_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mva_pkg::stat_t stat,
	output mva_pkg::ctrl_t ctrl
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DECODE = 8'b0000_0010,
		ST_SEC    = 8'b0000_0100,
		ST_FADE   = 8'b0000_1000,
		ST_FIND   = 8'b0001_0000,
		ST_START  = 8'b0010_0000,
		ST_SCAN   = 8'b0100_0000,
		ST_FLUSH  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Sequence commands and next state
	always_comb begin
		state_d = state_q;
		ctrl = '0;
		ctrl.mode = mva_pkg::MODE_FIND;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.kind)
					mva_pkg::KIND_ON: begin
						ctrl.sec_clr = 1'b1;
						state_d = ST_SEC;
					end
					mva_pkg::KIND_OFF, mva_pkg::KIND_CC: state_d = ST_SCAN;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SEC: begin
				if (stat.sec_done) begin
					state_d = ST_FLUSH;
				end else if (stat.sec_hit) begin
					state_d = ST_FADE;
				end else begin
					ctrl.sec_next = 1'b1;
				end
			end
			ST_FADE: begin
				ctrl.mode = mva_pkg::MODE_FADE;
				if (stat.emit_ok) begin
					ctrl.step = 1'b1;
					if (stat.scan_last) state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				ctrl.mode = mva_pkg::MODE_FIND;
				ctrl.step = 1'b1;
				if (stat.scan_last) state_d = ST_START;
			end
			ST_START: begin
				if (stat.emit_ok) begin
					ctrl.start = 1'b1;
					ctrl.sec_next = 1'b1;
					state_d = ST_SEC;
				end
			end
			ST_SCAN: begin
				ctrl.mode = (stat.kind == mva_pkg::KIND_OFF) ? mva_pkg::MODE_REL
					: mva_pkg::MODE_ALL;
				if (stat.emit_ok) begin
					ctrl.step = 1'b1;
					if (stat.scan_last) state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (stat.flush_ok) begin
					ctrl.flush = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

// ===== hdl/mva_datapath.sv =====
// Datapath of the MIDI voice allocator: item and config registers, voice
// table, scan index, steal search, pending and output result registers.
// Depends on mva_pkg.
module mva_datapath #(
	parameter int VOICE_COUNT   = 8,
	parameter int SECTION_COUNT = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [55:0]    cfg_data,
	input  logic           opcode,
	input  logic [7:0]     status_byte,
	input  logic [6:0]     data_one,
	input  logic [6:0]     data_two,
	input  logic [1:0]     byte_count,
	input  logic [2:0]     ended_voice,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     command,
	output logic [2:0]     voice_slot,
	output logic [2:0]     section,
	output logic [6:0]     note,
	output logic [6:0]     velocity,
	output logic           last,
	input  mva_pkg::ctrl_t ctrl,
	output mva_pkg::stat_t stat
);

	localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(VOICE_COUNT - 1);
	localparam logic [3:0] SEC_MAX = 4'(SECTION_COUNT);

	// configuration
	logic [3:0]  sec_count_q;
	logic [55:0] sec_notes_q;
	logic        loaded_q;

	// item
	mva_pkg::kind_t kind_q;
	logic [6:0] d1_q, d2_q;

	// voice table
	logic          act_q  [VOICE_COUNT];
	logic [2:0]    vsec_q [VOICE_COUNT];
	logic [6:0]    vnote_q[VOICE_COUNT];
	logic [31:0]   vser_q [VOICE_COUNT];
	logic [31:0]   next_ser_q;

	// scan
	logic [IW-1:0] idx_q;
	logic [3:0]    sec_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q, min_idx_q;
	logic [31:0]   min_ser_q;

	// results
	logic [4:0]  cnt_q;
	logic        pend_v_q;
	logic [1:0]  pend_cmd_q;
	logic [IW-1:0] pend_slot_q;
	logic [2:0]  pend_sec_q;
	logic [6:0]  pend_note_q, pend_vel_q;
	logic        out_v_q;
	logic [1:0]  out_cmd_q;
	logic [IW-1:0] out_slot_q;
	logic [2:0]  out_sec_q;
	logic [6:0]  out_note_q, out_vel_q;
	logic        out_last_q;

	logic [3:0]    secs_lim;
	logic [6:0]    trig;
	logic          match;
	logic          cand_v;
	logic [1:0]    cand_cmd;
	logic [IW-1:0] cand_slot, target;
	logic          out_free;
	logic [IW+2:0] slot_ext;
	mva_pkg::kind_t kind_in;
	logic [IW-1:0] ended_idx;

	// Decode the incoming message
	always_comb begin
		kind_in = mva_pkg::KIND_NONE;
		if (!opcode && byte_count >= 2'd2) begin
			if (status_byte[7:4] == mva_pkg::KIND_NOTE_ON && byte_count == 2'd3
					&& data_two != 7'd0) begin
				kind_in = loaded_q ? mva_pkg::KIND_ON : mva_pkg::KIND_NONE;
			end else if (status_byte[7:4] == mva_pkg::KIND_NOTE_OFF
					|| (status_byte[7:4] == mva_pkg::KIND_NOTE_ON
					&& byte_count == 2'd3)) begin
				kind_in = mva_pkg::KIND_OFF;
			end else if (status_byte[7:4] == mva_pkg::KIND_CONTROL
					&& (data_one == mva_pkg::CC_ALL_SOUND_OFF
					|| data_one == mva_pkg::CC_ALL_NOTES_OFF)) begin
				kind_in = mva_pkg::KIND_CC;
			end
		end
	end

	assign ended_idx = IW'(ended_voice);
	assign secs_lim  = (sec_count_q > SEC_MAX) ? SEC_MAX : sec_count_q;
	assign trig      = sec_notes_q[7 * sec_q[2:0] +: 7];
	assign target    = free_found_q ? free_idx_q : min_idx_q;

	// Match the scanned voice against the scan mode
	always_comb begin
		case (ctrl.mode)
			mva_pkg::MODE_FADE: match = act_q[idx_q] && vsec_q[idx_q] == sec_q[2:0];
			mva_pkg::MODE_REL:  match = act_q[idx_q] && vnote_q[idx_q] == d1_q;
			mva_pkg::MODE_ALL:  match = act_q[idx_q];
			default:            match = 1'b0;
		endcase
		cand_v    = (ctrl.step && match) || ctrl.start;
		cand_cmd  = ctrl.start ? mva_pkg::CMD_START
			: (ctrl.mode == mva_pkg::MODE_REL) ? mva_pkg::CMD_OFF : mva_pkg::CMD_FADE;
		cand_slot = ctrl.start ? target : idx_q;
	end

	assign out_free = !out_v_q || out_ready;

	assign stat.kind      = kind_q;
	assign stat.sec_done  = sec_q >= secs_lim;
	assign stat.sec_hit   = trig == d1_q;
	assign stat.scan_last = idx_q == LAST_IDX;
	assign stat.emit_ok   = !pend_v_q || out_free;
	assign stat.flush_ok  = !pend_v_q || out_free;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_count_q <= '0;
			sec_notes_q <= '0;
			loaded_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				mva_pkg::REG_SECTION_COUNT: sec_count_q <= cfg_data[3:0];
				mva_pkg::REG_SECTION_NOTES: sec_notes_q <= cfg_data;
				mva_pkg::REG_SAMPLE_LOADED: loaded_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Hold the item
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			d1_q <= data_one;
			d2_q <= data_two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kind_q <= mva_pkg::KIND_NONE;
		else if (ctrl.load) kind_q <= kind_in;
	end

	// Advance scan index, section index and steal search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			sec_q        <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			min_idx_q    <= '0;
			min_ser_q    <= '0;
		end else begin
			if (ctrl.load) idx_q <= '0;
			else if (ctrl.step) idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			if (ctrl.sec_clr) sec_q <= '0;
			else if (ctrl.sec_next) sec_q <= sec_q + 4'd1;
			if (ctrl.sec_clr || ctrl.sec_next) free_found_q <= 1'b0;
			else if (ctrl.step && ctrl.mode == mva_pkg::MODE_FIND) begin
				if (!act_q[idx_q] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_q;
				end
				if (idx_q == '0 || vser_q[idx_q] < min_ser_q) begin
					min_idx_q <= idx_q;
					min_ser_q <= vser_q[idx_q];
				end
			end
		end
	end

	// Update the voice table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ser_q <= '0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				act_q[i]   <= 1'b0;
				vsec_q[i]  <= '0;
				vnote_q[i] <= '0;
				vser_q[i]  <= '0;
			end
		end else begin
			if (ctrl.load && opcode && 32'(ended_voice) < 32'(VOICE_COUNT))
				act_q[ended_idx] <= 1'b0;
			if (ctrl.start) begin
				act_q[target]   <= 1'b1;
				vsec_q[target]  <= sec_q[2:0];
				vnote_q[target] <= d1_q;
				vser_q[target]  <= next_ser_q;
				next_ser_q      <= next_ser_q + 32'd1;
			end
		end
	end

	// Move results through pending and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			if (ctrl.load) cnt_q <= '0;
			if (cand_v && cnt_q < mva_pkg::MAX_RESULTS) begin
				cnt_q    <= cnt_q + 5'd1;
				pend_v_q <= 1'b1;
				if (pend_v_q) out_v_q <= 1'b1;
			end else if (ctrl.flush && pend_v_q) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cand_v && cnt_q < mva_pkg::MAX_RESULTS) begin
			pend_cmd_q  <= cand_cmd;
			pend_slot_q <= cand_slot;
			pend_sec_q  <= ctrl.start ? sec_q[2:0] : 3'd0;
			pend_note_q <= ctrl.start ? d1_q : 7'd0;
			pend_vel_q  <= ctrl.start ? d2_q : 7'd0;
		end
		if ((cand_v && cnt_q < mva_pkg::MAX_RESULTS && pend_v_q)
				|| (ctrl.flush && pend_v_q)) begin
			out_cmd_q  <= pend_cmd_q;
			out_slot_q <= pend_slot_q;
			out_sec_q  <= pend_sec_q;
			out_note_q <= pend_note_q;
			out_vel_q  <= pend_vel_q;
			out_last_q <= ctrl.flush;
		end
	end

	assign slot_ext   = {3'b000, out_slot_q};
	assign out_valid  = out_v_q;
	assign command    = out_cmd_q;
	assign voice_slot = slot_ext[2:0];
	assign section    = out_sec_q;
	assign note       = out_note_q;
	assign velocity   = out_vel_q;
	assign last       = out_last_q;

endmodule

// ===== hdl/midi_voice_allocator_unit.sv =====
// Top level of the MIDI voice allocator: controller plus datapath.
// Depends on mva_pkg, mva_ctrl and mva_datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | opcode status_byte data_one data_two
//          |                      | byte_count ended_voice
//  out     | out_valid / out_ready| command voice_slot section note velocity last
//  cfg     | cfg_we               | cfg_index cfg_data
//
// One transaction at a time: accept, decode, then scans over the voice table.
// A note-on walks the sections; each whose trigger note matches gets a fade
// scan, a find scan and a voice start. Note-off and control change scan once.
// A held output stalls the scan only when a second result is waiting.
// Reset clears the voice table, the serial counter and the configuration.
module midi_voice_allocator_unit #(
	parameter int VOICE_COUNT   = 8,
	parameter int SECTION_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [55:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  status_byte,
	input  logic [6:0]  data_one,
	input  logic [6:0]  data_two,
	input  logic [1:0]  byte_count,
	input  logic [2:0]  ended_voice,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  command,
	output logic [2:0]  voice_slot,
	output logic [2:0]  section,
	output logic [6:0]  note,
	output logic [6:0]  velocity,
	output logic        last
);

	mva_pkg::ctrl_t ctrl;
	mva_pkg::stat_t stat;

	mva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	mva_datapath #(
		.VOICE_COUNT   (VOICE_COUNT),
		.SECTION_COUNT (SECTION_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.status_byte (status_byte),
		.data_one    (data_one),
		.data_two    (data_two),
		.byte_count  (byte_count),
		.ended_voice (ended_voice),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.command     (command),
		.voice_slot  (voice_slot),
		.section     (section),
		.note        (note),
		.velocity    (velocity),
		.last        (last),
		.ctrl        (ctrl),
		.stat        (stat)
	);

endmodule

// ===== hdl/mva_checker.sv =====
// Port checker for the MIDI voice allocator, bound to the top level.
// Depends on mva_pkg and midi_voice_allocator_unit.
module mva_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] command,
	input logic [2:0] section,
	input logic [6:0] note,
	input logic [6:0] velocity,
	input logic       last
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command) && $stable(last))
		else $error("stalled result changed");

	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> command == mva_pkg::CMD_START || command == mva_pkg::CMD_FADE
			|| command == mva_pkg::CMD_OFF)
		else $error("undefined command");

	a_start_vel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command == mva_pkg::CMD_START |-> velocity != 7'd0)
		else $error("start with zero velocity");

	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command != mva_pkg::CMD_START
			|-> section == 3'd0 && note == 7'd0 && velocity == 7'd0)
		else $error("fade or note-off carries start fields");

endmodule

bind midi_voice_allocator_unit mva_checker u_mva_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.command   (command),
	.section   (section),
	.note      (note),
	.velocity  (velocity),
	.last      (last)
);
